// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the hash table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is applied.
`define EMHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define EMHT_ASSERT_NEVER(label, cond, msg) \
  `EMHT_ASSERT(label, !(cond), msg)

`endif

// ----- rtl/emht_pkg.sv -----
// Types, constants and helper functions of the exact-match hash table.
package emht_pkg;

  localparam int KEY_W   = 64;
  localparam int DIN_W   = 32;
  localparam int DOUT_W  = 32;
  localparam int COUNT_W = 11;
  localparam int KB_W    = 4;
  localparam int SUM_W   = 11;

  localparam logic [KB_W-1:0] KEY_BYTES_RESET = 4'd8;

  localparam int BUCKETS_DEFAULT    = 256;
  localparam int WAYS_DEFAULT       = 4;
  localparam int DATA_WIDTH_DEFAULT = 32;
  localparam int QUEUE_DEPTH        = 2;

  // Fraction bits of the reciprocal used for the bucket modulo.
  localparam int HASH_SHIFT = 22;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_NOT_FOUND,
    STATUS_DUPLICATE,
    STATUS_FULL
  } status_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } back_state_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
    logic [DIN_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [DOUT_W-1:0]  data_out;
    logic [COUNT_W-1:0] entry_count;
  } res_t;

  // A key length of zero acts as one byte, anything above eight as eight.
  function automatic logic [KB_W-1:0] eff_key_bytes(input logic [KB_W-1:0] kb);
    logic [KB_W-1:0] nb;
    nb = kb;
    if (kb == 4'd0) begin
      nb = 4'd1;
    end else if (kb > 4'd8) begin
      nb = 4'd8;
    end
    return nb;
  endfunction

endpackage

// ----- rtl/exact_match_hash_table.sv -----
// A result strobes after the three front stages, the queue, the bucket row read and
// the execute state. The engine takes one request at a time, reading and writing back
// the row on the single table memory; the front accepts back to back until its queue fills.
// busy stays high while the front pipeline is blocked by a full queue.
// After reset a clearing pass writes every bucket row, with busy high.
// Results cannot be stalled; each strobes for exactly one cycle.
module exact_match_hash_table #(
  parameter int BUCKETS    = emht_pkg::BUCKETS_DEFAULT,
  parameter int WAYS       = emht_pkg::WAYS_DEFAULT,
  parameter int DATA_WIDTH = emht_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  emht_pkg::req_t            req_i,
  input  logic                      cfg_we_i,
  input  logic [emht_pkg::KB_W-1:0] cfg_wdata_i,
  output logic                      res_valid_o,
  output emht_pkg::res_t            res_o
);

  localparam int BW = $clog2(BUCKETS);
  localparam int QW = $bits(emht_pkg::req_t) + BW;

  logic [emht_pkg::KB_W-1:0] key_bytes_q;
  logic                      accept;
  logic                      front_busy, clearing;
  logic                      push, pop, full, empty;
  emht_pkg::req_t            front_req, back_req;
  logic [BW-1:0]             front_bucket, back_bucket;
  logic [QW-1:0]             q_wdata, q_rdata;

  assign busy   = front_busy || clearing;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_bytes_q <= emht_pkg::KEY_BYTES_RESET;
    end else if (cfg_we_i) begin
      key_bytes_q <= cfg_wdata_i;
    end
  end

  emht_front #(
    .BUCKETS(BUCKETS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (req_i),
    .key_bytes_i (key_bytes_q),
    .full_i      (full),
    .busy_o      (front_busy),
    .push_o      (push),
    .req_o       (front_req),
    .bucket_o    (front_bucket)
  );

  assign q_wdata = {front_bucket, front_req};
  assign {back_bucket, back_req} = q_rdata;

  emht_fifo #(
    .WIDTH(QW),
    .DEPTH(emht_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .empty_o (empty)
  );

  emht_back #(
    .BUCKETS    (BUCKETS),
    .WAYS       (WAYS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_bytes_i (key_bytes_q),
    .empty_i     (empty),
    .req_i       (back_req),
    .bucket_i    (back_bucket),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

// ----- rtl/emht_front.sv -----
// Front end: accepts requests and works out the bucket over three stages.
`include "assert_macros.svh"

module emht_front #(
  parameter int BUCKETS = emht_pkg::BUCKETS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  emht_pkg::req_t                 req_i,
  input  logic [emht_pkg::KB_W-1:0]      key_bytes_i,
  input  logic                           full_i,
  output logic                           busy_o,
  output logic                           push_o,
  output emht_pkg::req_t                 req_o,
  output logic [$clog2(BUCKETS)-1:0]     bucket_o
);

  localparam int BW  = $clog2(BUCKETS);
  localparam int SW  = emht_pkg::SUM_W;
  localparam int MW  = emht_pkg::HASH_SHIFT;
  localparam int BCW = $clog2(BUCKETS + 1);
  localparam int PW  = SW + BCW;
  localparam logic [MW-1:0] RECIP = MW'((64'd1 << emht_pkg::HASH_SHIFT) / BUCKETS);

  logic                  v1_q, v2_q, v3_q;
  emht_pkg::req_t        req1_q, req2_q, req3_q;
  logic [SW-1:0]         sum1_q, sum2_q;
  logic [SW-1:0]         quot2_q;
  logic [BW-1:0]         bucket3_q;
  logic                  advance;
  logic [SW-1:0]         byte_sum;
  logic [emht_pkg::KB_W-1:0] nb;
  logic [SW+MW-1:0]      prod;
  logic [PW-1:0]         qb;
  logic [PW-1:0]         rem;

  // The whole pipeline moves unless the last stage is blocked by a full queue.
  assign advance = !v3_q || !full_i;
  assign busy_o  = !advance;
  assign push_o  = v3_q && !full_i;
  assign req_o   = req3_q;
  assign bucket_o = bucket3_q;

  always_comb begin
    nb       = emht_pkg::eff_key_bytes(key_bytes_i);
    byte_sum = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nb) begin
        byte_sum = byte_sum + SW'(req_i.key[8*i +: 8]);
      end
    end
  end

  // The reciprocal estimate is at most one below the true quotient.
  assign prod = (SW+MW)'(sum1_q) * (SW+MW)'(RECIP);

  always_comb begin
    qb  = PW'(quot2_q) * PW'(BUCKETS);
    rem = PW'(sum2_q) - qb;
    if (rem >= PW'(BUCKETS)) begin
      rem = rem - PW'(BUCKETS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (advance) begin
      v1_q <= accept_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      req1_q    <= req_i;
      sum1_q    <= byte_sum;
      req2_q    <= req1_q;
      sum2_q    <= sum1_q;
      quot2_q   <= prod[SW+MW-1:MW];
      req3_q    <= req2_q;
      bucket3_q <= rem[BW-1:0];
    end
  end

  `EMHT_ASSERT(a_front_holds_word, v3_q && full_i |=> v3_q,
               "front dropped a word while the queue was full")

endmodule

// ----- rtl/emht_fifo.sv -----
// Short queue between the front end and the table engine.
`include "assert_macros.svh"

module emht_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = emht_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  `EMHT_ASSERT_NEVER(a_fifo_overflow, push_i && full_o, "word pushed into a full queue")
  `EMHT_ASSERT_NEVER(a_fifo_underflow, pop_i && empty_o, "word popped from an empty queue")

endmodule

// ----- rtl/emht_back.sv -----
// Table engine: bucket memory, way compare, insert and delete write-back.
`include "assert_macros.svh"

module emht_back #(
  parameter int BUCKETS    = emht_pkg::BUCKETS_DEFAULT,
  parameter int WAYS       = emht_pkg::WAYS_DEFAULT,
  parameter int DATA_WIDTH = emht_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [emht_pkg::KB_W-1:0]  key_bytes_i,
  input  logic                       empty_i,
  input  emht_pkg::req_t             req_i,
  input  logic [$clog2(BUCKETS)-1:0] bucket_i,
  output logic                       pop_o,
  output logic                       clearing_o,
  output logic                       res_valid_o,
  output emht_pkg::res_t             res_o
);

  localparam int BW      = $clog2(BUCKETS);
  localparam int KW      = emht_pkg::KEY_W;
  localparam int DW      = DATA_WIDTH;
  localparam int KOFF    = WAYS;
  localparam int DOFF    = WAYS + WAYS * KW;
  localparam int RW      = WAYS * (1 + KW + DW);
  localparam int ENTRIES = BUCKETS * WAYS;
  localparam int CW      = $clog2(ENTRIES + 1);

  // One row per bucket: way valid bits, then the keys, then the data words.
  logic [RW-1:0]  row_mem [BUCKETS];
  logic [RW-1:0]  rd_row_q;

  emht_pkg::back_state_e state_q, state_d;
  logic [BW-1:0]  clr_idx_q, clr_idx_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  emht_pkg::req_t cur_req_q;
  logic [BW-1:0]  cur_bucket_q;
  logic           res_valid_q;
  emht_pkg::res_t res_q, res_d;

  logic           rd_en, wr_en, res_load;
  logic [BW-1:0]  wr_addr;
  logic [RW-1:0]  wr_row, new_row;
  logic [emht_pkg::KB_W-1:0] nb;
  logic [KW-1:0]  key_mask;
  logic [WAYS-1:0] match, free, hit_oh, free_oh;
  logic [DW-1:0]  hit_data, din_fit;
  logic [63:0]    din_ext, hit_ext;
  logic           hit_any, free_any;

  assign clearing_o  = (state_q == emht_pkg::BK_CLEAR);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    nb = emht_pkg::eff_key_bytes(key_bytes_i);
    for (int i = 0; i < 8; i++) begin
      key_mask[8*i +: 8] = (4'(i) < nb) ? 8'hFF : 8'h00;
    end
  end

  always_comb begin
    hit_data = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = rd_row_q[w] &&
                 (((rd_row_q[KOFF + w*KW +: KW] ^ cur_req_q.key) & key_mask) == '0);
      free[w]  = !rd_row_q[w];
    end
    // Lowest matching way and lowest free way win.
    hit_oh  = match & (~match + WAYS'(1));
    free_oh = free & (~free + WAYS'(1));
    for (int w = 0; w < WAYS; w++) begin
      if (hit_oh[w]) begin
        hit_data = hit_data | rd_row_q[DOFF + w*DW +: DW];
      end
    end
    hit_any  = |match;
    free_any = |free;
    din_ext  = 64'(cur_req_q.data_in);
    din_fit  = din_ext[DW-1:0];
    hit_ext  = 64'(hit_data);
  end

  always_comb begin
    new_row = rd_row_q;
    for (int w = 0; w < WAYS; w++) begin
      if (cur_req_q.mode == emht_pkg::MODE_INSERT) begin
        if (free_oh[w]) begin
          new_row[w]                  = 1'b1;
          new_row[KOFF + w*KW +: KW]  = cur_req_q.key;
          new_row[DOFF + w*DW +: DW]  = din_fit;
        end
      end else if (hit_oh[w]) begin
        new_row[w] = 1'b0;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    cnt_d     = cnt_q;
    pop_o     = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = cur_bucket_q;
    wr_row    = new_row;
    res_load  = 1'b0;
    res_d.status   = emht_pkg::STATUS_NOT_FOUND;
    res_d.data_out = '0;
    case (state_q)
      emht_pkg::BK_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx_q;
        wr_row  = '0;
        if (clr_idx_q == BW'(BUCKETS - 1)) begin
          state_d = emht_pkg::BK_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + BW'(1);
        end
      end
      emht_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          rd_en   = 1'b1;
          state_d = emht_pkg::BK_EXEC;
        end
      end
      emht_pkg::BK_EXEC: begin
        res_load = 1'b1;
        state_d  = emht_pkg::BK_IDLE;
        case (cur_req_q.mode)
          emht_pkg::MODE_INSERT: begin
            if (hit_any) begin
              res_d.status = emht_pkg::STATUS_DUPLICATE;
            end else if (!free_any) begin
              res_d.status = emht_pkg::STATUS_FULL;
            end else begin
              res_d.status = emht_pkg::STATUS_OK;
              wr_en        = 1'b1;
              cnt_d        = cnt_q + CW'(1);
            end
          end
          emht_pkg::MODE_DELETE: begin
            if (hit_any) begin
              res_d.status   = emht_pkg::STATUS_OK;
              res_d.data_out = hit_ext[emht_pkg::DOUT_W-1:0];
              wr_en          = 1'b1;
              if (cnt_q != '0) begin
                cnt_d = cnt_q - CW'(1);
              end
            end
          end
          emht_pkg::MODE_SEARCH: begin
            if (hit_any) begin
              res_d.status   = emht_pkg::STATUS_OK;
              res_d.data_out = hit_ext[emht_pkg::DOUT_W-1:0];
            end
          end
          default: begin
            res_d.status = emht_pkg::STATUS_NOT_FOUND;
          end
        endcase
      end
      default: begin
        state_d = emht_pkg::BK_IDLE;
      end
    endcase
    res_d.entry_count = emht_pkg::COUNT_W'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= emht_pkg::BK_CLEAR;
      clr_idx_q   <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_req_q    <= req_i;
      cur_bucket_q <= bucket_i;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      row_mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_q <= row_mem[bucket_i];
    end
  end

  `EMHT_ASSERT(a_res_after_exec, res_valid_q |-> $past(state_q == emht_pkg::BK_EXEC),
               "result strobe without a table access")
  `EMHT_ASSERT(a_cnt_only_exec, !$stable(cnt_q) |-> $past(state_q == emht_pkg::BK_EXEC),
               "entry count changed outside a table access")
  `EMHT_ASSERT(a_cnt_bound, cnt_q <= CW'(ENTRIES), "entry count above table size")

endmodule
